>>> rtl/rwc_pkg.sv
// Shared types and codes for the raycaster wall column setup block.
// No dependencies.
`default_nettype none
package rwc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PLAYER_POS_X    = 3'd0;
    localparam logic [2:0] CFG_PLAYER_POS_Y    = 3'd1;
    localparam logic [2:0] CFG_TEXTURE_WIDTHS  = 3'd2;
    localparam logic [2:0] CFG_TEXTURE_HEIGHTS = 3'd3;

    // Wall face codes, also the lane of the packed texture sizes
    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    // Request data riding through the distance divider
    typedef struct packed {
        logic        side;
        logic [1:0]  face;
        logic        mirror;
        logic [31:0] ray_dir;
        logic [31:0] perp;
    } t_ray_pay;

endpackage
`default_nettype wire

>>> rtl/rwc_div_cell.sv
// One restoring division step: one quotient bit, registered.
// Depends on nothing; used by rwc_divider.
`default_nettype none
module rwc_div_cell #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic      [NW-1:0] o_num,
    output logic      [DW-1:0] o_rem,
    output logic      [DW-1:0] o_div,
    output logic      [PW-1:0] o_pay
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_num;

    always_comb begin
        w_trial = {i_rem, i_num[NW-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        // dividend bits shift out on top, quotient bits shift in below
        n_num   = {i_num[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_num <= n_num;
        o_rem <= n_rem;
        o_div <= i_div;
        o_pay <= i_pay;
    end

endmodule
`default_nettype wire

>>> rtl/rwc_divider.sv
// Pipelined unsigned divider: a row of NW division cells, one per quotient bit.
// Depends on rwc_div_cell. Quotient of a zero divisor is all ones.
`default_nettype none
module rwc_divider #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_div,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic      [NW-1:0] o_quot,
    output logic      [PW-1:0] o_pay
);

    logic          c_valid [0:NW];
    logic [NW-1:0] c_num   [0:NW];
    logic [DW-1:0] c_rem   [0:NW];
    logic [DW-1:0] c_div   [0:NW];
    logic [PW-1:0] c_pay   [0:NW];

    assign c_valid[0] = i_valid;
    assign c_num[0]   = i_num;
    assign c_rem[0]   = '0;
    assign c_div[0]   = i_div;
    assign c_pay[0]   = i_pay;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        rwc_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .i_num   (c_num[k]),
            .i_rem   (c_rem[k]),
            .i_div   (c_div[k]),
            .i_pay   (c_pay[k]),
            .o_valid (c_valid[k+1]),
            .o_num   (c_num[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_div   (c_div[k+1]),
            .o_pay   (c_pay[k+1])
        );
    end

    assign o_valid = c_valid[NW];
    assign o_quot  = c_num[NW];
    assign o_pay   = c_pay[NW];

endmodule
`default_nettype wire

>>> rtl/raycast_wall_column_setup.sv
// Raycaster wall column setup: one ray hit in, one column descriptor out.
// Throughput: one request per cycle; busy is always low, results cannot be stalled.
// Pipeline: stage 0, the line height divider row (LW cells), stages 1 to 4,
// the texture step divider row (32 cells), then stages 5 and 6, where LW =
// clog2(SCREEN_HEIGHT*65536+1); each divider cell yields one quotient bit.
// Reset: synchronous active low; clears config registers and all valid bits.
`default_nettype none
module raycast_wall_column_setup
    import rwc_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_hit_side,
    input  wire logic [31:0] i_side_dist_x,
    input  wire logic [31:0] i_side_dist_y,
    input  wire logic [31:0] i_delta_dist_x,
    input  wire logic [31:0] i_delta_dist_y,
    input  wire logic [31:0] i_ray_dir_x,
    input  wire logic [31:0] i_ray_dir_y,
    input  wire logic        i_step_x_negative,
    input  wire logic        i_step_y_negative,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    // result
    output logic             o_strobe,
    output logic [8:0]       o_draw_start,
    output logic [8:0]       o_draw_end,
    output logic [30:0]      o_line_height,
    output logic [1:0]       o_texture_index,
    output logic [15:0]      o_texture_column,
    output logic [31:0]      o_texture_step,
    output logic [31:0]      o_texture_start
);

    localparam int NUMER  = SCREEN_HEIGHT * 65536;   // screen height in Q16.16
    localparam int LW     = $clog2(NUMER + 1);       // line height width
    localparam int HALF_H = SCREEN_HEIGHT / 2;
    localparam int LAT    = LW + 39;                 // accept to sampled strobe

    typedef struct packed {
        logic [8:0]    ds;
        logic [8:0]    de;
        logic [LW-1:0] lh;
        logic [1:0]    face;
        logic [15:0]   col;
        logic [LW-2:0] off;
    } t_col_pay;

    // ---------------- configuration ----------------
    logic [31:0] r_pos_x;
    logic [31:0] r_pos_y;
    logic [63:0] r_tex_w;
    logic [63:0] r_tex_h;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;   // fully pipelined, a request every cycle

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_tex_w <= '0;
            r_tex_h <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PLAYER_POS_X:    r_pos_x <= i_cfg_data[31:0];
                CFG_PLAYER_POS_Y:    r_pos_y <= i_cfg_data[31:0];
                CFG_TEXTURE_WIDTHS:  r_tex_w <= i_cfg_data;
                CFG_TEXTURE_HEIGHTS: r_tex_h <= i_cfg_data;
                default: ;           // unknown index: write dropped
            endcase
        end
    end

    // ---------------- stage 0: perpendicular distance, face ----------------
    logic        w_accept;
    logic [32:0] w_diff;
    t_ray_pay    n0_pay;
    logic        r0_valid;
    t_ray_pay    r0_pay;

    assign w_accept = start && !busy;

    always_comb begin
        w_diff = i_hit_side ? ({1'b0, i_side_dist_y} - {1'b0, i_delta_dist_y})
                            : ({1'b0, i_side_dist_x} - {1'b0, i_delta_dist_x});
        n0_pay.side = i_hit_side;
        // distance not positive: clamp to one LSB
        n0_pay.perp = (w_diff[32] || (w_diff == 33'd0)) ? 32'd1 : w_diff[31:0];
        if (!i_hit_side) begin
            n0_pay.face = i_step_x_negative ? FACE_EAST : FACE_WEST;
        end else begin
            n0_pay.face = i_step_y_negative ? FACE_SOUTH : FACE_NORTH;
        end
        n0_pay.mirror  = (!i_hit_side && i_step_x_negative) ||
                         (i_hit_side && !i_step_y_negative);
        // y-side hits use the x ray component, x-side hits the y component
        n0_pay.ray_dir = i_hit_side ? i_ray_dir_x : i_ray_dir_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_pay <= n0_pay;
    end

    // ---------------- line height divider ----------------
    logic          d1_valid;
    logic [LW-1:0] d1_quot;
    t_ray_pay      d1_pay;

    rwc_divider #(.NW(LW), .DW(32), .PW($bits(t_ray_pay))) u_div_lh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_num   (LW'(NUMER)),
        .i_div   (r0_pay.perp),
        .i_pay   (r0_pay),
        .o_valid (d1_valid),
        .o_quot  (d1_quot),
        .o_pay   (d1_pay)
    );

    // ---------------- stage 1: draw rows, wall product ----------------
    logic [LW-2:0] w_half;
    logic          w_tall;
    logic [LW-2:0] w_ds;
    logic [LW-1:0] w_de_sum;
    logic [LW-1:0] w_de;
    logic [63:0]   w_prod;

    logic          r1_valid;
    logic [31:0]   r1_prod;
    logic          r1_side;
    logic          r1_mirror;
    t_col_pay      r1_pay;

    always_comb begin
        w_half   = d1_quot[LW-1:1];
        w_tall   = (w_half >= (LW-1)'(HALF_H));
        w_ds     = w_tall ? '0 : ((LW-1)'(HALF_H) - w_half);
        w_de_sum = {1'b0, w_half} + LW'(HALF_H);
        w_de     = (w_de_sum >= LW'(SCREEN_HEIGHT)) ? LW'(SCREEN_HEIGHT - 1) : w_de_sum;
        // only the low word of the wall position matters
        w_prod   = d1_pay.perp * d1_pay.ray_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod     <= w_prod[31:0];
        r1_side     <= d1_pay.side;
        r1_mirror   <= d1_pay.mirror;
        r1_pay.ds   <= w_ds[8:0];
        r1_pay.de   <= w_de[8:0];
        r1_pay.lh   <= d1_quot;
        r1_pay.face <= d1_pay.face;
        r1_pay.col  <= '0;
        r1_pay.off  <= w_tall ? (w_half - (LW-1)'(HALF_H)) : '0;
    end

    // ---------------- stage 2: wall fraction ----------------
    logic        r2_valid;
    logic [15:0] r2_frac;
    logic        r2_mirror;
    t_col_pay    r2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_frac   <= r1_prod[31:16] + (r1_side ? r_pos_x[15:0] : r_pos_y[15:0]);
        r2_mirror <= r1_mirror;
        r2_pay    <= r1_pay;
    end

    // ---------------- stage 3: scale to texture width ----------------
    logic [15:0] w_width3;
    logic [31:0] w_col_prod;
    logic        r3_valid;
    logic [15:0] r3_col;
    logic        r3_mirror;
    t_col_pay    r3_pay;

    always_comb begin
        w_width3   = r_tex_w[16*r2_pay.face +: 16];
        w_col_prod = r2_frac * w_width3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_col    <= w_col_prod[31:16];
        r3_mirror <= r2_mirror;
        r3_pay    <= r2_pay;
    end

    // ---------------- stage 4: mirror column ----------------
    logic [15:0] w_width4;
    t_col_pay    n4_pay;
    logic        r4_valid;
    t_col_pay    r4_pay;

    assign w_width4 = r_tex_w[16*r3_pay.face +: 16];

    always_comb begin
        n4_pay     = r3_pay;
        // zero width wraps to 0xFFFF, as intended
        n4_pay.col = r3_mirror ? (w_width4 - r3_col - 16'd1) : r3_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_pay <= n4_pay;
    end

    // ---------------- texture step divider ----------------
    // zero line height gives an all-ones quotient: the saturated step
    logic        d2_valid;
    logic [31:0] d2_quot;
    t_col_pay    d2_pay;

    rwc_divider #(.NW(32), .DW(LW), .PW($bits(t_col_pay))) u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_valid),
        .i_num   ({r_tex_h[16*r4_pay.face +: 16], 16'h0000}),
        .i_div   (r4_pay.lh),
        .i_pay   (r4_pay),
        .o_valid (d2_valid),
        .o_quot  (d2_quot),
        .o_pay   (d2_pay)
    );

    // ---------------- stage 5: texture start product ----------------
    logic [LW+30:0] r5_start;
    logic [31:0]    r5_step;
    logic           r5_valid;
    t_col_pay       r5_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_start <= d2_pay.off * d2_quot;
        r5_step  <= d2_quot;
        r5_pay   <= d2_pay;
    end

    // ---------------- stage 6: result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_draw_start     <= r5_pay.ds;
        o_draw_end       <= r5_pay.de;
        o_line_height    <= 31'(r5_pay.lh);
        o_texture_index  <= r5_pay.face;
        o_texture_column <= r5_pay.col;
        o_texture_step   <= r5_step;
        o_texture_start  <= (r5_start > (LW+31)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                 : r5_start[31:0];
    end

`ifndef SYNTHESIS
    // every accepted request leaves the pipe after a fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_strobe)
        else $error("result strobe missing at fixed latency");

    // saturated step appears exactly for a zero line height
    a_step_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_line_height == 31'd0) == (o_texture_step == 32'hFFFF_FFFF)))
        else $error("texture step saturation mismatch");

    // zero line height must give a zero texture start
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_line_height == 31'd0)) |-> (o_texture_start == 32'd0))
        else $error("texture start not zero for zero line height");
`endif

endmodule
`default_nettype wire
